/* hdl/lss_pkg.sv */
// Shared types and constants for the line sprite scan block.
package lss_pkg;

	localparam int MAX_PER_LINE_DEF  = 10;
	localparam int TABLE_ENTRIES_DEF = 40;
	localparam int QUEUE_DEPTH       = 4;
	localparam int SPR_W             = 8;
	localparam int PADDR_W           = 1;

	localparam logic [PADDR_W-1:0] REG_TALL_SPRITES = 1'b0;

	localparam logic [SPR_W:0] LINE_OFFSET  = 9'd16;
	localparam logic [SPR_W:0] HEIGHT_SHORT = 9'd8;
	localparam logic [SPR_W:0] HEIGHT_TALL  = 9'd16;

	typedef struct packed {
		logic [SPR_W-1:0] attr;
		logic [SPR_W-1:0] tile;
		logic [SPR_W-1:0] x;
		logic [SPR_W-1:0] y;
	} ent_t;

	typedef struct packed {
		logic ins;
		logic last;
		ent_t ent;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LIST,
		BK_EMPTY
	} bk_state_t;

endpackage

/* hdl/lss_front.sv */
// Front end: accepts table entries, tests them against the line, issues insert/flush requests.
module lss_front import lss_pkg::*; #(
	parameter int MAX_PER_LINE  = MAX_PER_LINE_DEF,
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tall,
	input  logic             in_valid,
	input  logic [SPR_W-1:0] line,
	input  ent_t             ent,
	input  logic             last,
	input  q_stat_t          q_stat,
	output logic             in_ready,
	output logic             push,
	output cmd_t             cmd
);

	localparam int SEEN_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CNT_W  = $clog2(MAX_PER_LINE + 1);

	logic [SEEN_W-1:0] seen_q;
	logic [CNT_W-1:0]  sel_cnt_q;
	logic              accept;
	logic              counted;
	logic              hit;
	logic [SPR_W:0]    line_ref;
	logic [SPR_W:0]    y_top;
	logic [SPR_W:0]    y_bot;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	assign line_ref = {1'b0, line} + LINE_OFFSET;
	assign y_top    = {1'b0, ent.y};
	assign y_bot    = y_top + (tall ? HEIGHT_TALL : HEIGHT_SHORT);
	assign counted  = seen_q < SEEN_W'(TABLE_ENTRIES);
	assign hit      = counted && (ent.x != '0) && (sel_cnt_q < CNT_W'(MAX_PER_LINE)) &&
	                  (y_top <= line_ref) && (y_bot > line_ref);

	// only selected entries and scan ends go to the back end
	assign push     = accept && (hit || last);
	assign cmd.ins  = hit;
	assign cmd.last = last;
	assign cmd.ent  = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			sel_cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				seen_q    <= '0;
				sel_cnt_q <= '0;
			end else begin
				if (counted)
					seen_q <= seen_q + 1'b1;
				if (hit)
					sel_cnt_q <= sel_cnt_q + 1'b1;
			end
		end
	end

endmodule

/* hdl/lss_queue.sv */
// Short request queue between the front and back ends.
module lss_queue import lss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hdl/lss_back.sv */
// Back end: sorted insert into a row of slots, then emit the list through an output register.
module lss_back import lss_pkg::*; #(
	parameter int MAX_PER_LINE = MAX_PER_LINE_DEF,
	localparam int CNT_W       = $clog2(MAX_PER_LINE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cmd_t             q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_entry_valid,
	output ent_t             out_ent,
	output logic             out_last,
	output logic [CNT_W-1:0] kept_cnt
);

	bk_state_t        state_q;
	bk_state_t        state_d;
	ent_t             slot_q   [MAX_PER_LINE];
	ent_t             slot_ins [MAX_PER_LINE];
	logic             take     [MAX_PER_LINE];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_after;
	logic             out_adv;
	logic             do_ins;
	logic             do_shift;
	logic             load_list;
	logic             load_empty;

	assign kept_cnt  = cnt_q;
	assign out_adv   = !out_valid || out_ready;
	assign cnt_after = cnt_q + CNT_W'(q_head.ins);

	// slots at and after the insert point move up one place
	always_comb begin
		for (int i = 0; i < MAX_PER_LINE; i++)
			take[i] = (CNT_W'(i) < cnt_q) && (slot_q[i].x > q_head.ent.x);
		for (int i = 0; i < MAX_PER_LINE; i++) begin
			if (i > 0 && take[(i > 0) ? i - 1 : 0])
				slot_ins[i] = slot_q[(i > 0) ? i - 1 : 0];
			else if (take[i] || CNT_W'(i) == cnt_q)
				slot_ins[i] = q_head.ent;
			else
				slot_ins[i] = slot_q[i];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && q_head.last)
					state_d = (cnt_after == '0) ? BK_EMPTY : BK_LIST;
			end
			BK_LIST: begin
				if (out_adv && cnt_q == CNT_W'(1))
					state_d = BK_IDLE;
			end
			BK_EMPTY: begin
				if (out_adv)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		do_ins     = 1'b0;
		do_shift   = 1'b0;
		load_list  = 1'b0;
		load_empty = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop  = q_valid;
				do_ins = q_valid && q_head.ins;
			end
			BK_LIST: begin
				load_list = out_adv;
				do_shift  = out_adv;
			end
			BK_EMPTY: load_empty = out_adv;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_ins)
				cnt_q <= cnt_after;
			else if (do_shift)
				cnt_q <= cnt_q - 1'b1;
			if (load_list || load_empty)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins) begin
			for (int i = 0; i < MAX_PER_LINE; i++)
				slot_q[i] <= slot_ins[i];
		end else if (do_shift) begin
			for (int i = 0; i < MAX_PER_LINE - 1; i++)
				slot_q[i] <= slot_q[i + 1];
		end
		if (load_list) begin
			out_entry_valid <= 1'b1;
			out_ent         <= slot_q[0];
			out_last        <= cnt_q == CNT_W'(1);
		end else if (load_empty) begin
			out_entry_valid <= 1'b0;
			out_ent         <= '0;
			out_last        <= 1'b1;
		end
	end

endmodule

/* hdl/line_sprite_select_sort.sv */
// Top level of the line sprite scan: register port, front end, queue, sort/emit back end.
//
//  port group        dir  width  contents
//  s_t*  (entries)   in   40+1   scan_line, sprite_y, sprite_x, sprite_tile, sprite_attr; last
//  m_t*  (results)   out  32+1+1 out_y, out_x, out_tile, out_attr; entry_valid; is_last
//  p*    (registers) in   1 reg  tall_sprites at byte address 0
//
// The front end takes one entry per cycle while the 4-deep request queue has room.
// The back end pops each request in turn, doing a sorted insert for a selected entry; a
// scan end starts the emit of the kept sprites in ascending x order (or of the empty result).
// Requests wait in the queue while a list is being emitted.
// Reset clears the counters, queue and output valid; slot contents need no reset.
// A stalled result output holds the back end; the front end stalls only on a full queue.
module line_sprite_select_sort import lss_pkg::*; #(
	parameter int MAX_PER_LINE  = MAX_PER_LINE_DEF,
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [39:0]        s_tdata,  // scan_line, sprite_y, sprite_x, sprite_tile, sprite_attr
	input  logic               s_tlast,  // last_entry
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,  // out_y, out_x, out_tile, out_attr
	output logic [0:0]         m_tuser,  // entry_valid
	output logic               m_tlast   // is_last
);

	localparam int CNT_W = $clog2(MAX_PER_LINE + 1);

	logic             tall_q;
	logic             push;
	cmd_t             push_cmd;
	cmd_t             head;
	q_stat_t          q_stat;
	logic             pop;
	ent_t             in_ent;
	ent_t             out_ent;
	logic             out_entry_valid;
	logic [CNT_W-1:0] kept_cnt;

	assign pready = 1'b1;
	assign prdata = {31'b0, tall_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tall_q <= 1'b0;
		else if (psel && penable && pwrite && pready && paddr == REG_TALL_SPRITES)
			tall_q <= pwdata[0];
	end

	assign in_ent.y    = s_tdata[15:8];
	assign in_ent.x    = s_tdata[23:16];
	assign in_ent.tile = s_tdata[31:24];
	assign in_ent.attr = s_tdata[39:32];

	lss_front #(
		.MAX_PER_LINE  (MAX_PER_LINE),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tall     (tall_q),
		.in_valid (s_tvalid),
		.line     (s_tdata[7:0]),
		.ent      (in_ent),
		.last     (s_tlast),
		.q_stat   (q_stat),
		.in_ready (s_tready),
		.push     (push),
		.cmd      (push_cmd)
	);

	lss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	lss_back #(
		.MAX_PER_LINE (MAX_PER_LINE)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (!q_stat.empty),
		.q_head          (head),
		.q_pop           (pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_entry_valid (out_entry_valid),
		.out_ent         (out_ent),
		.out_last        (m_tlast),
		.kept_cnt        (kept_cnt)
	);

	assign m_tdata    = {out_ent.attr, out_ent.tile, out_ent.x, out_ent.y};
	assign m_tuser[0] = out_entry_valid;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("request pushed into a full queue");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0)
		else $error("empty-list result not final or not zero");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_cnt <= CNT_W'(MAX_PER_LINE))
		else $error("kept sprite count above limit");

endmodule
